@@ sv/pese_pkg.sv @@
`default_nettype none

package pese_pkg;

  // Stack geometry and word size.
  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Request types carried by req_type.
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_OPER   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  // Operator codes carried by op_code.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Kinds of stack update applied when a beat is committed.
  localparam logic [1:0] K_HOLD   = 2'd0;
  localparam logic [1:0] K_PUSH   = 2'd1;
  localparam logic [1:0] K_OPER   = 2'd2;
  localparam logic [1:0] K_FINISH = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       load_alu;
    logic       div_start;
    logic       commit;
    logic [1:0] kind;
    logic [1:0] status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req;
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       lt2;
    logic       divz;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/pese_divider.sv @@
`default_nettype none

module pese_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [pese_pkg::DATA_WIDTH-1:0] dividend,
  input  wire logic [pese_pkg::DATA_WIDTH-1:0] divisor,
  output logic                                done,
  output logic [pese_pkg::DATA_WIDTH-1:0]      quotient
);
  import pese_pkg::*;

  localparam int STEP_W = $clog2(DATA_WIDTH);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] mag_b;
  logic                  neg;

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   trial;
  logic                  last;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh = {rem, quo[DATA_WIDTH-1]};
    trial  = rem_sh - {1'b0, mag_b};
    last   = (step == STEP_W'(DATA_WIDTH - 1));
  end

  // Control: busy for DATA_WIDTH steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Magnitude datapath; the sign of the answer is applied on the way out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[DATA_WIDTH-1] ? (~dividend + DATA_WIDTH'(1)) : dividend;
      mag_b <= divisor[DATA_WIDTH-1] ? (~divisor + DATA_WIDTH'(1)) : divisor;
      neg   <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      rem   <= '0;
    end else if (busy) begin
      if (!trial[DATA_WIDTH]) begin
        rem <= trial[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + DATA_WIDTH'(1)) : quo;

endmodule

`default_nettype wire

@@ sv/pese_datapath.sv @@
`default_nettype none

module pese_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pese_pkg::ctrl_cmd_t             cmd,
  output pese_pkg::dp_stat_t                   stat,
  input  wire logic [1:0]                      req_type,
  input  wire logic [pese_pkg::DATA_WIDTH-1:0] operand_value,
  input  wire logic [1:0]                      op_code,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic [1:0]                           status,
  output logic [pese_pkg::DATA_WIDTH-1:0]      top_value,
  output logic                                 is_final
);
  import pese_pkg::*;

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cnt_m2;
  logic [DATA_WIDTH-1:0] top_reg;
  logic [DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH-1:0] alu_res;
  logic [1:0]            req_l;
  logic [1:0]            op_l;
  logic [DATA_WIDTH-1:0] val_l;

  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_q;

  // The second entry from the top is read every cycle; it is the right operand.
  assign cnt_m2 = count - CNT_W'(2);

  always_comb begin
    mem_we    = cmd.commit && ((cmd.kind == K_PUSH) || (cmd.kind == K_OPER));
    mem_waddr = (cmd.kind == K_PUSH) ? count[PTR_W-1:0] : cnt_m2[PTR_W-1:0];
    mem_wdata = (cmd.kind == K_PUSH) ? val_l : res;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cnt_m2[PTR_W-1:0]];
  end

  // Add, subtract and multiply of top (left) and second (right).
  always_comb begin
    case (op_l)
      OP_ADD:  alu_res = top_reg + rd_data;
      OP_SUB:  alu_res = top_reg - rd_data;
      OP_MUL:  alu_res = DATA_WIDTH'(top_reg * rd_data);
      default: alu_res = '0;
    endcase
  end

  pese_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (top_reg),
    .divisor  (rd_data),
    .done     (div_done),
    .quotient (div_q)
  );

  // Status toward the controller.
  always_comb begin
    stat.req      = req_l;
    stat.op       = op_l;
    stat.full     = (count == CNT_W'(STACK_DEPTH));
    stat.empty    = (count == '0);
    stat.lt2      = (count < CNT_W'(2));
    stat.divz     = (op_l == OP_DIV) && (rd_data == '0);
    stat.div_done = div_done;
    stat.out_free = !rsp_valid || !rsp_stall;
  end

  // Input beat capture and the answer register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_l <= req_type;
      op_l  <= op_code;
      val_l <= operand_value;
    end
    if (div_done) begin
      res <= div_q;
    end else if (cmd.load_alu) begin
      res <= alu_res;
    end
  end

  // Stack count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
        case (cmd.kind)
          K_PUSH:   count <= count + CNT_W'(1);
          K_OPER:   count <= count - CNT_W'(1);
          K_FINISH: count <= '0;
          default:  count <= count;
        endcase
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Cached top of stack and the output beat.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status   <= cmd.status;
      is_final <= (cmd.kind == K_FINISH);
      case (cmd.kind)
        K_PUSH: begin
          top_reg   <= val_l;
          top_value <= val_l;
        end
        K_OPER: begin
          top_reg   <= res;
          top_value <= res;
        end
        K_FINISH: begin
          top_value <= top_reg;
        end
        default: begin
          top_value <= (count == '0) ? '0 : top_reg;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/pese_ctrl.sv @@
`default_nettype none

module pese_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire pese_pkg::dp_stat_t stat,
  output pese_pkg::ctrl_cmd_t     cmd
);
  import pese_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DISPATCH = 2'd1;
  localparam logic [1:0] S_DIVWAIT  = 2'd2;
  localparam logic [1:0] S_COMMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] kind;
  logic [1:0] kind_next;
  logic [1:0] code;
  logic [1:0] code_next;

  assign req_stall = rst || (state != S_IDLE);

  // Sequencing of one beat: decode, optional divide, commit.
  always_comb begin
    state_next    = state;
    kind_next     = kind;
    code_next     = code;
    cmd.accept    = 1'b0;
    cmd.load_alu  = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    cmd.kind      = kind;
    cmd.status    = code;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_COMMIT;
        kind_next  = K_HOLD;
        code_next  = ST_OK;
        unique case (stat.req)
          REQ_PUSH: begin
            if (stat.full) begin
              code_next = ST_OVER;
            end else begin
              kind_next = K_PUSH;
            end
          end
          REQ_OPER: begin
            if (stat.lt2) begin
              code_next = ST_UNDER;
            end else if (stat.divz) begin
              code_next = ST_DIVZ;
            end else if (stat.op == OP_DIV) begin
              kind_next     = K_OPER;
              cmd.div_start = 1'b1;
              state_next    = S_DIVWAIT;
            end else begin
              kind_next    = K_OPER;
              cmd.load_alu = 1'b1;
            end
          end
          REQ_FINISH: begin
            if (stat.empty) begin
              code_next = ST_UNDER;
            end else begin
              kind_next = K_FINISH;
            end
          end
          default: begin
            kind_next = K_HOLD;
          end
        endcase
      end
      S_DIVWAIT: begin
        if (stat.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    code <= code_next;
  end

endmodule

`default_nettype wire

@@ sv/prefix_expression_stack_evaluator_unit.sv @@
// Channel   Handshake              Payload
// request   req_valid / req_stall  req_type, operand_value, op_code
// response  rsp_valid / rsp_stall  status, top_value, is_final
//
// One request beat at a time: each beat passes through the idle (accept), dispatch
// and commit states, and a divide adds a wait state for the one-bit-a-step divider;
// commit loads the response register once the response slot is free.
// Reset is synchronous; it empties the stack, and no clearing pass runs.
// A stalled response holds; the next request is taken while it waits, and
// that request's commit waits until the response slot is free.
`default_nettype none

module prefix_expression_stack_evaluator_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic [1:0]                      req_type,
  input  wire logic [pese_pkg::DATA_WIDTH-1:0] operand_value,
  input  wire logic [1:0]                      op_code,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic [1:0]                           status,
  output logic [pese_pkg::DATA_WIDTH-1:0]      top_value,
  output logic                                 is_final
);
  import pese_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pese_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pese_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .operand_value (operand_value),
    .op_code       (op_code),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .top_value     (top_value),
    .is_final      (is_final)
  );

endmodule

`default_nettype wire

@@ sv/pese_checker.sv @@
`default_nettype none

module pese_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_stall,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_stall,
  input wire logic [1:0]                      status,
  input wire logic [pese_pkg::DATA_WIDTH-1:0] top_value,
  input wire logic                            is_final
);
  import pese_pkg::*;

  // Reset leaves no response pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A taken request beat closes the request side until it is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in flight");

  // A final answer is only given by a clean finish.
  a_final_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && is_final) |-> (status == ST_OK))
    else $error("final answer with error status");

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(status) && $stable(top_value) && $stable(is_final)))
    else $error("stalled response changed");

endmodule

bind prefix_expression_stack_evaluator_unit pese_checker u_pese_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .status    (status),
  .top_value (top_value),
  .is_final  (is_final)
);

`default_nettype wire
